### rtl/fcc_pkg.sv
package fcc_pkg;

  localparam int ROW_W   = 10;
  localparam int SIDE_W  = 11;
  localparam int TIDX_W  = 12;
  localparam int RGBA_W  = 32;
  localparam int PIX_W   = 20;
  localparam int CFG_W   = 32;
  localparam int CFGA_W  = 3;
  localparam int DVSR_W  = 10;
  localparam int DIST_W  = 34;
  localparam int LAT_W   = 23;
  localparam int SHQ_W   = 17;
  localparam int FRAC_W  = 30;
  localparam int RHEAD_W = 13;

  localparam logic [DIST_W-1:0] SHADE_SAT_DIST = DIST_W'(2949120);
  localparam logic [SHQ_W-1:0]  SHADE_ONE      = SHQ_W'(65536);

  typedef enum logic [CFGA_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_VX     = 3'd2,
    CFG_VY     = 3'd3,
    CFG_COS    = 3'd4,
    CFG_SIN    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [31:0]       vx;
    logic [31:0]       vy;
    logic [15:0]       vcos;
    logic [15:0]       vsin;
  } cfg_t;

  typedef struct packed {
    logic              wr;
    logic              sel;
    logic [TIDX_W-1:0] tidx;
    logic [RGBA_W-1:0] tdata;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic              bad;
    logic              hz;
    logic [DVSR_W-1:0] dvsr;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0]  fidx;
    logic [PIX_W-1:0]  cidx;
    logic [RGBA_W-1:0] frgba;
    logic [RGBA_W-1:0] crgba;
    logic              bad;
  } res_t;

  typedef struct packed {
    logic adv;
  } back_sts_t;

  // scale RGB by a Q1.16 factor, keep alpha
  function automatic logic [RGBA_W-1:0] shade_rgba(input logic [RGBA_W-1:0] rgba,
                                                   input logic [SHQ_W-1:0] shade);
    logic [24:0]       p;
    logic [RGBA_W-1:0] res;
    res = rgba;
    for (int s = 1; s < 4; s++) begin
      p = rgba[8*s +: 8] * shade;
      res[8*s +: 8] = p[23:16];
    end
    return res;
  endfunction

endpackage

### rtl/floor_ceiling_texture_caster.sv
// Floor and ceiling pixel caster with two 32-bit texel stores.
// Input channel (push/full): one transaction is either a texel write
// (action 0: texture_select, texel_index, texel_rgba) or a render request
// (action 1: row, column). A write gives no result; a render request gives
// exactly one result: floor and mirrored ceiling pixel index, both shaded
// colours, and bad_request for a refused pixel (all other fields zero).
// Result channel (empty/pop): the oldest result sits on the ports while
// empty is low and leaves on a pop.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
// (0 width, 1 height, 2 viewer x, 3 viewer y, 4 cosine, 5 sine); write
// only while no transaction is in flight.
// Throughput is one transaction per cycle while the result queue has room.
// A render request reaches the result ports through the bit-serial row
// distance divider (34 stages) and lateral step divider (23 stages).
// When the receiver stops popping, the two-entry result queue fills, the
// whole pipeline holds, then the two-entry input queue fills and full rises.
// Reset empties both queues and the pipeline and loads the default screen
// and view; texel contents are undefined until written.
module floor_ceiling_texture_caster #(
  parameter int TEX_SIDE        = 64,
  parameter int MAX_SCREEN_SIDE = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        action_i,
  input  logic [fcc_pkg::ROW_W-1:0]   row_i,
  input  logic [fcc_pkg::ROW_W-1:0]   column_i,
  input  logic                        texture_select_i,
  input  logic [fcc_pkg::TIDX_W-1:0]  texel_index_i,
  input  logic [fcc_pkg::RGBA_W-1:0]  texel_rgba_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [fcc_pkg::PIX_W-1:0]   floor_index_o,
  output logic [fcc_pkg::PIX_W-1:0]   ceiling_index_o,
  output logic [fcc_pkg::RGBA_W-1:0]  floor_rgba_o,
  output logic [fcc_pkg::RGBA_W-1:0]  ceiling_rgba_o,
  output logic                        bad_request_o,
  input  logic                        cfg_we_i,
  input  logic [fcc_pkg::CFGA_W-1:0]  cfg_addr_i,
  input  logic [fcc_pkg::CFG_W-1:0]   cfg_wdata_i
);

  logic [fcc_pkg::SIDE_W-1:0] w_q, h_q, side_d;
  logic [31:0]                vx_q, vy_q;
  logic [15:0]                cos_q, sin_q;
  fcc_pkg::cfg_t              cfg;

  // clamp screen sides
  always_comb begin
    if (32'(cfg_wdata_i[fcc_pkg::SIDE_W-1:0]) > MAX_SCREEN_SIDE) begin
      side_d = fcc_pkg::SIDE_W'(MAX_SCREEN_SIDE);
    end else begin
      side_d = cfg_wdata_i[fcc_pkg::SIDE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= fcc_pkg::SIDE_W'(320);
      h_q   <= fcc_pkg::SIDE_W'(200);
      vx_q  <= '0;
      vy_q  <= '0;
      cos_q <= 16'd16384;
      sin_q <= '0;
    end else if (cfg_we_i) begin
      unique case (fcc_pkg::cfg_reg_e'(cfg_addr_i))
        fcc_pkg::CFG_WIDTH:  w_q   <= side_d;
        fcc_pkg::CFG_HEIGHT: h_q   <= side_d;
        fcc_pkg::CFG_VX:     vx_q  <= cfg_wdata_i;
        fcc_pkg::CFG_VY:     vy_q  <= cfg_wdata_i;
        fcc_pkg::CFG_COS:    cos_q <= cfg_wdata_i[15:0];
        fcc_pkg::CFG_SIN:    sin_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{width: w_q, height: h_q, vx: vx_q, vy: vy_q, vcos: cos_q, vsin: sin_q};

  fcc_pkg::item_t     head;
  logic               head_valid, take;
  fcc_pkg::back_sts_t sts;

  fcc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .push             (push),
    .full             (full),
    .action_i         (action_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .texture_select_i (texture_select_i),
    .texel_index_i    (texel_index_i),
    .texel_rgba_i     (texel_rgba_i),
    .head_o           (head),
    .head_valid_o     (head_valid),
    .take_i           (take)
  );

  fcc_back #(.TEX_SIDE(TEX_SIDE)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .head_i          (head),
    .head_valid_i    (head_valid),
    .take_o          (take),
    .empty           (empty),
    .pop             (pop),
    .floor_index_o   (floor_index_o),
    .ceiling_index_o (ceiling_index_o),
    .floor_rgba_o    (floor_rgba_o),
    .ceiling_rgba_o  (ceiling_rgba_o),
    .bad_request_o   (bad_request_o),
    .sts_o           (sts)
  );

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sts.adv |-> !empty)
    else $error("pipeline held with no waiting result");

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bad_request_o) |-> (floor_index_o == '0 && ceiling_index_o == '0 &&
                                   floor_rgba_o == '0 && ceiling_rgba_o == '0))
    else $error("refused pixel carries nonzero fields");

  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("input queue filled without a transaction");

  a_take_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (head_valid && sts.adv))
    else $error("back end took from an empty input queue");

endmodule

### rtl/fcc_div.sv
module fcc_div #(
  parameter int DEN_W = 10,
  parameter int Q_W   = 34
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [Q_W-1:0]   lo_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   lo_q  [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  logic [DEN_W-1:0] rin  [Q_W];
  logic [Q_W-1:0]   lin  [Q_W];
  logic [DEN_W-1:0] din  [Q_W];
  logic [Q_W-1:0]   qin  [Q_W];
  logic [DEN_W:0]   t    [Q_W];
  logic [DEN_W:0]   diff [Q_W];
  logic [Q_W-1:0]   ge;

  for (genvar k = 0; k < Q_W; k++) begin : g_stg
    if (k == 0) begin : g_first
      assign rin[k] = rem_i;
      assign lin[k] = lo_i;
      assign din[k] = den_i;
      assign qin[k] = '0;
    end else begin : g_next
      assign rin[k] = rem_q[k-1];
      assign lin[k] = lo_q[k-1];
      assign din[k] = den_q[k-1];
      assign qin[k] = quo_q[k-1];
    end
    assign t[k]    = {rin[k], lin[k][Q_W-1]};
    assign diff[k] = t[k] - {1'b0, din[k]};
    assign ge[k]   = t[k] >= {1'b0, din[k]};
  end

  // one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Q_W; k++) begin
        rem_q[k] <= ge[k] ? diff[k][DEN_W-1:0] : t[k][DEN_W-1:0];
        lo_q[k]  <= {lin[k][Q_W-2:0], 1'b0};
        den_q[k] <= din[k];
        quo_q[k] <= {qin[k][Q_W-2:0], ge[k]};
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

### rtl/fcc_front.sv
module fcc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fcc_pkg::cfg_t                cfg_i,
  input  logic                         push,
  output logic                         full,
  input  logic                         action_i,
  input  logic [fcc_pkg::ROW_W-1:0]    row_i,
  input  logic [fcc_pkg::ROW_W-1:0]    column_i,
  input  logic                         texture_select_i,
  input  logic [fcc_pkg::TIDX_W-1:0]   texel_index_i,
  input  logic [fcc_pkg::RGBA_W-1:0]   texel_rgba_i,
  output fcc_pkg::item_t               head_o,
  output logic                         head_valid_o,
  input  logic                         take_i
);

  fcc_pkg::item_t    it;
  fcc_pkg::item_t    fq_q [2];
  logic [1:0]        cnt_q;
  logic              wp_q, rp_q;
  logic              do_push;
  logic signed [11:0] dd;

  always_comb begin
    dd       = $signed({1'b0, row_i, 1'b0}) - $signed({1'b0, cfg_i.height});
    it.wr    = !action_i;
    it.sel   = texture_select_i;
    it.tidx  = texel_index_i;
    it.tdata = texel_rgba_i;
    it.row   = row_i;
    it.col   = column_i;
    it.bad   = ({1'b0, column_i} >= cfg_i.width) ||
               ({1'b0, row_i} < (cfg_i.height >> 1)) ||
               ({1'b0, row_i} >= cfg_i.height);
    it.hz    = dd[11] || (dd == '0);
    // horizon row divides by one, result is masked later
    it.dvsr  = it.hz ? fcc_pkg::DVSR_W'(1) : dd[fcc_pkg::DVSR_W-1:0];
  end

  assign full         = (cnt_q == 2'd2);
  assign do_push      = push && !full;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = fq_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (take_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) fq_q[wp_q] <= it;
  end

endmodule

### rtl/fcc_back.sv
module fcc_back #(
  parameter int TEX_SIDE = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fcc_pkg::cfg_t               cfg_i,
  input  fcc_pkg::item_t              head_i,
  input  logic                        head_valid_i,
  output logic                        take_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [fcc_pkg::PIX_W-1:0]   floor_index_o,
  output logic [fcc_pkg::PIX_W-1:0]   ceiling_index_o,
  output logic [fcc_pkg::RGBA_W-1:0]  floor_rgba_o,
  output logic [fcc_pkg::RGBA_W-1:0]  ceiling_rgba_o,
  output logic                        bad_request_o,
  output fcc_pkg::back_sts_t          sts_o
);

  localparam int TEX_LOG = $clog2(TEX_SIDE);
  localparam int AW      = 2 * TEX_LOG;
  localparam int DEPTH   = TEX_SIDE * TEX_SIDE;
  localparam int SUM_W   = fcc_pkg::FRAC_W + TEX_LOG;
  localparam int L1      = fcc_pkg::DIST_W;
  localparam int L2      = fcc_pkg::LAT_W;
  localparam int SHD     = fcc_pkg::LAT_W - fcc_pkg::SHQ_W;
  localparam int DW      = fcc_pkg::DIST_W;

  logic adv;
  logic [1:0] oq_cnt_q;

  assign adv    = (oq_cnt_q != 2'd2);
  assign take_o = adv && head_valid_i;
  assign sts_o  = '{adv: adv};

  // row distance divider
  logic [DW-1:0] n1;
  logic [DW-1:0] row_dist;
  logic [17:0]   h96;

  assign h96 = {1'b0, cfg_i.height, 6'b0} + {2'b0, cfg_i.height, 5'b0};
  assign n1  = {h96, 16'b0};

  fcc_div #(.DEN_W(fcc_pkg::DVSR_W), .Q_W(DW)) u_div_dist (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i ('0),
    .lo_i  (n1),
    .den_i (head_i.dvsr),
    .quo_o (row_dist)
  );

  logic [L1-1:0]  v1_q;
  fcc_pkg::item_t it1_q [L1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= '0;
    else if (adv) v1_q <= {v1_q[L1-2:0], take_o};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q[0] <= head_i;
      for (int k = 1; k < L1; k++) it1_q[k] <= it1_q[k-1];
    end
  end

  // lateral step and shade dividers run side by side
  logic [DW+1:0]               num2;
  logic [fcc_pkg::LAT_W-1:0]   lat;
  logic [fcc_pkg::SHQ_W-1:0]   shq;
  logic                        sat;

  assign num2 = {2'b0, row_dist} + {1'b0, row_dist, 1'b0};
  assign sat  = (row_dist <= fcc_pkg::SHADE_SAT_DIST);

  fcc_div #(.DEN_W(fcc_pkg::RHEAD_W), .Q_W(fcc_pkg::LAT_W)) u_div_lat (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i (num2[DW+1:fcc_pkg::LAT_W]),
    .lo_i  (num2[fcc_pkg::LAT_W-1:0]),
    .den_i ({cfg_i.height, 2'b0}),
    .quo_o (lat)
  );

  fcc_div #(.DEN_W(DW), .Q_W(fcc_pkg::SHQ_W)) u_div_shade (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i (fcc_pkg::SHADE_SAT_DIST),
    .lo_i  ('0),
    .den_i (row_dist),
    .quo_o (shq)
  );

  logic [L2-1:0]             v2_q;
  fcc_pkg::item_t            it2_q   [L2];
  logic [DW-1:0]             dist2_q [L2];
  logic [L2-1:0]             sat2_q;
  logic [fcc_pkg::SHQ_W-1:0] shq_q   [SHD];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= '0;
    else if (adv) v2_q <= {v2_q[L2-2:0], v1_q[L1-1]};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it2_q[0]   <= it1_q[L1-1];
      dist2_q[0] <= row_dist;
      sat2_q     <= {sat2_q[L2-2:0], sat};
      for (int k = 1; k < L2; k++) begin
        it2_q[k]   <= it2_q[k-1];
        dist2_q[k] <= dist2_q[k-1];
      end
      shq_q[0] <= shq;
      for (int k = 1; k < SHD; k++) shq_q[k] <= shq_q[k-1];
    end
  end

  // first products, pixel indices, final shade
  fcc_pkg::item_t      it_e;
  logic [DW-1:0]       dist_e;
  logic signed [DW+16:0] pdx, pdy;
  logic signed [11:0]  off;
  logic signed [27:0]  os, oc;
  logic [33:0]         x3, y3;
  logic [20:0]         rw, fsum;
  logic [10:0]         hr;
  logic [21:0]         crw, csum;
  logic [fcc_pkg::SHQ_W-1:0] shq_e, shade;

  always_comb begin
    it_e   = it2_q[L2-1];
    dist_e = dist2_q[L2-1];
    shq_e  = shq_q[SHD-1];
    pdx    = $signed({1'b0, dist_e}) * $signed(cfg_i.vcos);
    pdy    = $signed({1'b0, dist_e}) * $signed(cfg_i.vsin);
    off    = $signed({2'b0, cfg_i.width[10:1]}) - $signed({2'b0, it_e.col});
    os     = off * $signed(cfg_i.vsin);
    oc     = off * $signed(cfg_i.vcos);
    x3     = {{2{cfg_i.vx[31]}}, cfg_i.vx} + {cfg_i.vx[31], cfg_i.vx, 1'b0};
    y3     = {{2{cfg_i.vy[31]}}, cfg_i.vy} + {cfg_i.vy[31], cfg_i.vy, 1'b0};
    rw     = {11'b0, it_e.row} * {10'b0, cfg_i.width};
    fsum   = {11'b0, it_e.col} + rw;
    hr     = cfg_i.height - {1'b0, it_e.row};
    crw    = {11'b0, hr} * {11'b0, cfg_i.width};
    csum   = {12'b0, it_e.col} + crw;
    if (it_e.hz) begin
      shade = '0;
    end else if (sat2_q[L2-1] || (shq_e > fcc_pkg::SHADE_ONE)) begin
      shade = fcc_pkg::SHADE_ONE;
    end else begin
      shade = shq_e;
    end
  end

  logic                      v_x1_q;
  fcc_pkg::item_t            it_x1_q;
  logic [fcc_pkg::LAT_W-1:0] lat_x1_q;
  logic [fcc_pkg::SHQ_W-1:0] sh_x1_q;
  logic [SUM_W-1:0]          dcx_x1_q, dcy_x1_q, xb_x1_q, yb_x1_q;
  logic signed [27:0]        os_x1_q, oc_x1_q;
  logic [fcc_pkg::PIX_W-1:0] fi_x1_q, ci_x1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_x1_q  <= it_e;
      lat_x1_q <= lat;
      sh_x1_q  <= shade;
      dcx_x1_q <= pdx[SUM_W-1:0];
      dcy_x1_q <= pdy[SUM_W-1:0];
      xb_x1_q  <= {x3[SUM_W-19:0], 18'b0};
      yb_x1_q  <= {y3[SUM_W-19:0], 18'b0};
      os_x1_q  <= os;
      oc_x1_q  <= oc;
      fi_x1_q  <= fsum[fcc_pkg::PIX_W-1:0];
      ci_x1_q  <= csum[fcc_pkg::PIX_W-1:0];
    end
  end

  // lateral terms
  logic signed [51:0] ptx, pty;

  assign ptx = os_x1_q * $signed({1'b0, lat_x1_q});
  assign pty = oc_x1_q * $signed({1'b0, lat_x1_q});

  logic                      v_x2_q;
  fcc_pkg::item_t            it_x2_q;
  logic [fcc_pkg::SHQ_W-1:0] sh_x2_q;
  logic [SUM_W-1:0]          dcx_x2_q, dcy_x2_q, xb_x2_q, yb_x2_q, tx_x2_q, ty_x2_q;
  logic [fcc_pkg::PIX_W-1:0] fi_x2_q, ci_x2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_x2_q  <= it_x1_q;
      sh_x2_q  <= sh_x1_q;
      dcx_x2_q <= dcx_x1_q;
      dcy_x2_q <= dcy_x1_q;
      xb_x2_q  <= xb_x1_q;
      yb_x2_q  <= yb_x1_q;
      tx_x2_q  <= ptx[SUM_W-1:0];
      ty_x2_q  <= pty[SUM_W-1:0];
      fi_x2_q  <= fi_x1_q;
      ci_x2_q  <= ci_x1_q;
    end
  end

  // texture point, wrapped to the texture side
  logic [SUM_W-1:0] sx, sy;
  logic [AW-1:0]    raddr, addr;

  always_comb begin
    sx    = xb_x2_q + dcx_x2_q + tx_x2_q;
    sy    = yb_x2_q + dcy_x2_q - ty_x2_q;
    raddr = it_x2_q.hz ? '0 : {sy[SUM_W-1:fcc_pkg::FRAC_W], sx[SUM_W-1:fcc_pkg::FRAC_W]};
    addr  = it_x2_q.wr ? AW'(it_x2_q.tidx) : raddr;
  end

  logic                       v_x3_q;
  logic                       wr_x3_q, sel_x3_q, bad_x3_q;
  logic [fcc_pkg::RGBA_W-1:0] td_x3_q;
  logic [AW-1:0]              addr_x3_q;
  logic [fcc_pkg::SHQ_W-1:0]  sh_x3_q;
  logic [fcc_pkg::PIX_W-1:0]  fi_x3_q, ci_x3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr_x3_q   <= it_x2_q.wr;
      sel_x3_q  <= it_x2_q.sel;
      bad_x3_q  <= it_x2_q.bad;
      td_x3_q   <= it_x2_q.tdata;
      addr_x3_q <= addr;
      sh_x3_q   <= sh_x2_q;
      fi_x3_q   <= fi_x2_q;
      ci_x3_q   <= ci_x2_q;
    end
  end

  // texel stores: writes and reads stay in item order
  logic [fcc_pkg::RGBA_W-1:0] fmem [DEPTH];
  logic [fcc_pkg::RGBA_W-1:0] cmem [DEPTH];
  logic [fcc_pkg::RGBA_W-1:0] frd_q, crd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (v_x3_q && wr_x3_q && !sel_x3_q) fmem[addr_x3_q] <= td_x3_q;
      frd_q <= fmem[addr_x3_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (v_x3_q && wr_x3_q && sel_x3_q) cmem[addr_x3_q] <= td_x3_q;
      crd_q <= cmem[addr_x3_q];
    end
  end

  logic                      v_m_q, wr_m_q, bad_m_q;
  logic [fcc_pkg::SHQ_W-1:0] sh_m_q;
  logic [fcc_pkg::PIX_W-1:0] fi_m_q, ci_m_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr_m_q  <= wr_x3_q;
      bad_m_q <= bad_x3_q;
      sh_m_q  <= sh_x3_q;
      fi_m_q  <= fi_x3_q;
      ci_m_q  <= ci_x3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_x1_q <= 1'b0;
      v_x2_q <= 1'b0;
      v_x3_q <= 1'b0;
      v_m_q  <= 1'b0;
    end else if (adv) begin
      v_x1_q <= v2_q[L2-1];
      v_x2_q <= v_x1_q;
      v_x3_q <= v_x2_q;
      v_m_q  <= v_x3_q;
    end
  end

  // result queue
  fcc_pkg::res_t res, oq_q [2];
  logic          oq_wp_q, oq_rp_q;
  logic          oq_push, oq_pop;

  always_comb begin
    if (bad_m_q) begin
      res = '{fidx: '0, cidx: '0, frgba: '0, crgba: '0, bad: 1'b1};
    end else begin
      res = '{fidx:  fi_m_q,
              cidx:  ci_m_q,
              frgba: fcc_pkg::shade_rgba(frd_q, sh_m_q),
              crgba: fcc_pkg::shade_rgba(crd_q, sh_m_q),
              bad:   1'b0};
    end
  end

  assign oq_push = adv && v_m_q && !wr_m_q;
  assign oq_pop  = pop && !empty;
  assign empty   = (oq_cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_cnt_q <= '0;
      oq_wp_q  <= 1'b0;
      oq_rp_q  <= 1'b0;
    end else begin
      if (oq_push) oq_wp_q <= !oq_wp_q;
      if (oq_pop)  oq_rp_q <= !oq_rp_q;
      oq_cnt_q <= oq_cnt_q + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_q[oq_wp_q] <= res;
  end

  assign floor_index_o   = oq_q[oq_rp_q].fidx;
  assign ceiling_index_o = oq_q[oq_rp_q].cidx;
  assign floor_rgba_o    = oq_q[oq_rp_q].frgba;
  assign ceiling_rgba_o  = oq_q[oq_rp_q].crgba;
  assign bad_request_o   = oq_q[oq_rp_q].bad;

endmodule
